/* src/lever_frame_interlock_unit_macros.svh */
// Assertion macros for the lever frame interlock unit.
// Used by the top level; expects clk and rst in scope.
`ifndef LEVER_FRAME_INTERLOCK_UNIT_MACROS_SVH
`define LEVER_FRAME_INTERLOCK_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LFI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LFI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lfi_pkg.sv */
// Shared constants, codes and types for the lever frame interlock unit.
// No dependencies.
package lfi_pkg;

  localparam int LEVER_COUNT  = 20;
  localparam int LEVER_W      = 5;
  localparam int LEVER_IDX_W  = (LEVER_COUNT > 1) ? $clog2(LEVER_COUNT) : 1;
  localparam int ROW_BITS_W   = 40;
  localparam int CODE_VEC_W   = 2 * LEVER_COUNT;
  localparam int LEVER_BITS_W = 20;
  localparam int CMD_W        = 2;
  localparam int ROW_ADDR_W   = LEVER_W + 1;
  localparam int ROW_DEPTH    = 2 ** ROW_ADDR_W;
  localparam int IN_DATA_W    = 48;
  localparam int OUT_DATA_W   = 32;

  // Command codes carried on the input tuser
  localparam logic [CMD_W-1:0] CMD_MOVE        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOCK_ROW    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE_ROW = 2'd2;

  // Per-lever row codes
  localparam logic [1:0] CODE_MUST_PULL   = 2'd1;
  localparam logic [1:0] CODE_MUST_NORMAL = 2'd2;

  // Row bank select, top bit of the row memory address
  localparam logic ROW_SEL_LOCK    = 1'b0;
  localparam logic ROW_SEL_RELEASE = 1'b1;

  typedef logic [LEVER_COUNT-1:0] pos_vec_t;
  typedef logic [ROW_BITS_W-1:0]  row_t;

  typedef struct packed {
    logic               is_move;
    logic [LEVER_W-1:0] lever;
    logic               pulled;
  } item_t;

  typedef struct packed {
    logic                    frame_legal;
    logic                    move_sent;
    logic                    blocker_found;
    logic [LEVER_W-1:0]      blocking_lever;
    logic [LEVER_BITS_W-1:0] lever_bits;
  } result_t;

endpackage

/* src/lfi_row_mem.sv */
// Locking and release row memory, one synchronous write and one registered read.
// Entries never written read as zero (no constraint). Depends on lfi_pkg.
module lfi_row_mem
  import lfi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [ROW_ADDR_W-1:0] wr_addr,
  input  row_t                  wr_data,
  input  logic                  rd_en,
  input  logic [ROW_ADDR_W-1:0] rd_addr,
  output row_t                  rd_data
);

  row_t                 mem [ROW_DEPTH];
  logic [ROW_DEPTH-1:0] written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= written[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

/* src/lfi_check.sv */
// Frame state and move check: requested and committed positions, legal flag.
// Checks one move against its row and commits it when no blocker is found. Depends on lfi_pkg.
module lfi_check
  import lfi_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  row_t    row,
  output result_t res
);

  pos_vec_t requested, requested_next;
  pos_vec_t committed, committed_next;
  logic     legal, legal_next;

  logic [CODE_VEC_W-1:0]  row_ext;
  logic [LEVER_IDX_W-1:0] idx;
  pos_vec_t               viol;
  pos_vec_t               flag_vec;
  logic                   found;
  logic [LEVER_W-1:0]     blocker;
  logic [1:0]             code;

  always_comb begin
    row_ext        = CODE_VEC_W'(row);
    idx            = item.lever[LEVER_IDX_W-1:0];
    requested_next = requested;
    committed_next = committed;
    legal_next     = legal;
    viol           = '0;
    code           = '0;

    if (item.is_move) begin
      requested_next[idx] = item.pulled;
    end

    for (int i = 0; i < LEVER_COUNT; i++) begin
      code    = row_ext[2*i +: 2];
      viol[i] = (LEVER_W'(i) != item.lever) &&
                ((code == CODE_MUST_PULL && !requested_next[i]) ||
                 (code == CODE_MUST_NORMAL && requested_next[i]));
    end

    // Legal frame checks the row; an illegal frame looks for any mismatch
    flag_vec = legal ? viol : (requested_next ^ committed);
    found    = item.is_move && (|flag_vec);
    blocker  = '0;
    for (int i = LEVER_COUNT - 1; i >= 0; i--) begin
      if (flag_vec[i]) begin
        blocker = LEVER_W'(i);
      end
    end
    if (!found) begin
      blocker = '0;
    end

    if (item.is_move) begin
      legal_next = !found;
      if (!found) begin
        committed_next[idx] = item.pulled;
      end
    end

    res.frame_legal    = legal_next;
    res.move_sent      = item.is_move && !found;
    res.blocker_found  = found;
    res.blocking_lever = blocker;
    res.lever_bits     = LEVER_BITS_W'(committed_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      requested <= '0;
      committed <= '0;
      legal     <= 1'b1;
    end else if (fire) begin
      requested <= requested_next;
      committed <= committed_next;
      legal     <= legal_next;
    end
  end

endmodule

/* src/lever_frame_interlock_unit.sv */
// Channel  Dir  Signals                         Carries
// s_axis   in   tvalid tready tdata tuser       move or row write
// m_axis   out  tvalid tready tdata             one result per item
//
// The row memory read is registered together with the item; the check and commit
// then feed the result into an output register. A new item is taken
// every cycle while results drain, so sustained rate without stalls is one item per cycle.
// Reset clears positions and row valid bits; no clearing pass is needed.
// A stalled result holds the check stage, which in turn holds the input.
// Depends on lfi_pkg, lfi_row_mem, lfi_check and the assertion macro header.
`include "lever_frame_interlock_unit_macros.svh"

module lever_frame_interlock_unit
  import lfi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [4:0] lever, [5] pulled, [45:6] row_bits, [47:46] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] frame_legal, [1] move_sent, [2] blocker_found, [7:3] blocking_lever,
  // [27:8] lever_bits, [31:28] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic               in_fire, out_free, s1_fire, s1_valid;
  logic [CMD_W-1:0]   cmd;
  logic [LEVER_W-1:0] lever;
  logic               pulled;
  row_t               row_in;
  logic               in_range;
  logic               is_row_wr;
  logic               wr_en;
  logic [ROW_ADDR_W-1:0] wr_addr, rd_addr;
  row_t               rd_row;
  item_t              s1_item;
  result_t            res, out_res;

  assign cmd    = s_axis_tuser;
  assign lever  = s_axis_tdata[LEVER_W-1:0];
  assign pulled = s_axis_tdata[LEVER_W];
  assign row_in = s_axis_tdata[LEVER_W+1 +: ROW_BITS_W];

  assign in_range  = {1'b0, lever} < (LEVER_W + 1)'(LEVER_COUNT);
  assign is_row_wr = (cmd == CMD_LOCK_ROW) || (cmd == CMD_RELEASE_ROW);

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_fire       = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign wr_en   = in_fire && in_range && is_row_wr;
  assign wr_addr = {(cmd == CMD_RELEASE_ROW) ? ROW_SEL_RELEASE : ROW_SEL_LOCK, lever};
  assign rd_addr = {pulled ? ROW_SEL_LOCK : ROW_SEL_RELEASE, lever};

  lfi_row_mem u_row_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (row_in),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_row)
  );

  // Check stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item.is_move <= (cmd == CMD_MOVE) && in_range;
      s1_item.lever   <= lever;
      s1_item.pulled  <= pulled;
    end
  end

  lfi_check u_check (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_fire),
    .item (s1_item),
    .row  (rd_row),
    .res  (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = OUT_DATA_W'({out_res.lever_bits, out_res.blocking_lever,
                                     out_res.blocker_found, out_res.move_sent,
                                     out_res.frame_legal});

  `LFI_ASSERT_IMP(a_sent_is_legal, m_axis_tvalid && out_res.move_sent, out_res.frame_legal, "sent move on illegal frame")
  `LFI_ASSERT_IMP(a_blocked_not_sent, m_axis_tvalid && out_res.blocker_found, !out_res.move_sent, "blocked move reported sent")
  `LFI_ASSERT_IMP(a_accept_drains, in_fire && s1_valid, s1_fire, "item accepted over a held check stage")
  `LFI_ASSERT_NXT(a_nonmove_quiet, s1_fire && !s1_item.is_move, !out_res.move_sent && !out_res.blocker_found, "non-move item reported a move")

endmodule
